### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted record list merge.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/srlm_pkg.sv
// Package of the sorted record list merge: command and status codes.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package srlm_pkg;

   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Request commands
   localparam cmd_type CMD_LOAD_FIRST  = 3'd0;
   localparam cmd_type CMD_LOAD_SECOND = 3'd1;
   localparam cmd_type CMD_MERGE       = 3'd2;
   localparam cmd_type CMD_READ        = 3'd3;
   localparam cmd_type CMD_CLEAR       = 3'd4;

   // Status codes
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_RECORD_ERR = 2'd1;
   localparam status_type STATUS_OVERFLOW   = 2'd2;

endpackage

### hw/rtl/srlm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the list stores of the merge block.
`timescale 1ns / 1ps

module srlm_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word when enabled, read one word every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sorted_record_list_merge.sv
// Sorted record list merge: two list stores, one output store and the merge sequencer.
// Depends on srlm_pkg, srlm_ram and assert_macros.svh.
//
// Usage: each request on the req_ channel carries a command in req_tuser and a
// list word and an output index in req_tdata. Load commands append the word to the
// first or second list, merge walks both lists and rebuilds the output list, read
// returns the output word at the index, clear empties all lists and the status.
// Every request gives exactly one response on the rsp_ channel with the read word
// (zero unless a read), the output length and the sticky status.
// Timing: requests are taken one at a time; req_tready is high only while the
// sequencer is idle. Load, clear and unused commands pass through the decode and
// response states; read adds a wait state for the registered RAM read. Merge time
// grows with each output word and with each record pair, set by the single read
// port of each list RAM and the shared key/member comparator.
// The response sits in an output register; the next request is accepted while it
// waits, and the sequencer holds its next response until rsp_tready frees the slot.
// Reset clears the list counts, the output length, the status and the sequencer;
// list contents are undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_record_list_merge #(
   parameter int LIST_WORDS = 1024,
   parameter int RANK_BITS  = 16,
   localparam int W      = RANK_BITS + 1,
   localparam int MW     = 2 * LIST_WORDS,
   localparam int IDXW   = $clog2(MW),
   localparam int LENW   = $clog2(MW + 1),
   localparam int IN_DW  = ((W + IDXW + 7) / 8) * 8,
   localparam int OUT_DW = ((W + LENW + srlm_pkg::STATUS_W + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [IN_DW-1:0]             req_tdata,  // value, index
   input  logic [srlm_pkg::CMD_W-1:0]   req_tuser,  // command
   // response channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [OUT_DW-1:0]            rsp_tdata   // word, length, status
);

   localparam int AW   = $clog2(LIST_WORDS);
   localparam int CNTW = $clog2(LIST_WORDS + 1);
   localparam int SUMW = ((CNTW > W) ? CNTW : W) + 2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_EXEC, ST_READ_WAIT,
      ST_A_CHK, ST_A_CNT, ST_A_KEY,
      ST_B_CHK, ST_B_CNT, ST_B_KEY,
      ST_SEL, ST_FIT, ST_W_CNT,
      ST_MEM_RD, ST_MEM_CMP,
      ST_CP_RD, ST_CP_WR,
      ST_FINISH, ST_RESP
   } state_type;

   // control registers
   state_type                state_ff, state_in;
   logic [CNTW-1:0]          first_count_ff, first_count_in;
   logic [CNTW-1:0]          second_count_ff, second_count_in;
   logic [LENW-1:0]          merged_count_ff, merged_count_in;
   srlm_pkg::status_type     error_ff, error_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload registers
   srlm_pkg::cmd_type        cmd_ff, cmd_in;
   logic [W-1:0]             value_ff, value_in;
   logic [IDXW-1:0]          index_ff, index_in;
   logic [CNTW-1:0]          a_ff, a_in, b_ff, b_in;
   logic [CNTW-1:0]          ca_ff, ca_in, cb_ff, cb_in;
   logic [CNTW-1:0]          p_ff, p_in, q_ff, q_in;
   logic [CNTW-1:0]          need_ff, need_in;
   logic [W-1:0]             ka_ff, ka_in, kb_ff, kb_in;
   logic [W-1:0]             word_ff, word_in;
   srlm_pkg::status_type     code_ff, code_in;
   logic                     has_a_ff, has_a_in, has_b_ff, has_b_in;
   logic                     src_b_ff, src_b_in;
   logic [OUT_DW-1:0]        rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                     fl_we, sl_we, ml_we;
   logic [AW-1:0]            fl_waddr, fl_raddr, sl_waddr, sl_raddr;
   logic [W-1:0]             fl_wdata, fl_rdata, sl_wdata, sl_rdata;
   logic [IDXW-1:0]          ml_waddr, ml_raddr;
   logic [W-1:0]             ml_wdata, ml_rdata;

   // shared record checker and comparator
   logic                     rec_on_b;
   logic [CNTW-1:0]          rec_pos, rec_n;
   logic [W-1:0]             rec_word;
   logic                     rec_at_end, rec_short, rec_cnt_bad;
   logic [W-1:0]             cmp_x, cmp_y;
   logic                     cmp_lt, cmp_gt;
   logic                     take_a;
   logic [LENW:0]            fit_sum;

   srlm_ram #(.WIDTH(W), .DEPTH(LIST_WORDS)) u_first_ram (
      .clock   (clock),
      .wr_en   (fl_we),
      .wr_addr (fl_waddr),
      .wr_data (fl_wdata),
      .rd_addr (fl_raddr),
      .rd_data (fl_rdata)
   );

   srlm_ram #(.WIDTH(W), .DEPTH(LIST_WORDS)) u_second_ram (
      .clock   (clock),
      .wr_en   (sl_we),
      .wr_addr (sl_waddr),
      .wr_data (sl_wdata),
      .rd_addr (sl_raddr),
      .rd_data (sl_rdata)
   );

   srlm_ram #(.WIDTH(W), .DEPTH(MW)) u_merged_ram (
      .clock   (clock),
      .wr_en   (ml_we),
      .wr_addr (ml_waddr),
      .wr_data (ml_wdata),
      .rd_addr (ml_raddr),
      .rd_data (ml_rdata)
   );

   // Record bounds check, shared by both lists
   assign rec_on_b    = (state_ff == ST_B_CHK) || (state_ff == ST_B_CNT);
   assign rec_pos     = rec_on_b ? b_ff : a_ff;
   assign rec_n       = rec_on_b ? second_count_ff : first_count_ff;
   assign rec_word    = rec_on_b ? sl_rdata : fl_rdata;
   assign rec_at_end  = rec_pos >= rec_n;
   assign rec_short   = ((CNTW+1)'(rec_pos) + 1'b1) >= (CNTW+1)'(rec_n);
   assign rec_cnt_bad = rec_word[W-1] || (rec_word == '0) ||
                        ((SUMW'(rec_pos) + SUMW'(rec_word) + SUMW'(2)) > SUMW'(rec_n));

   // Shared signed comparator: keys in selection, members in the member merge
   assign cmp_x  = (state_ff == ST_SEL) ? ka_ff : fl_rdata;
   assign cmp_y  = (state_ff == ST_SEL) ? kb_ff : sl_rdata;
   assign cmp_lt = $signed(cmp_x) < $signed(cmp_y);
   assign cmp_gt = $signed(cmp_x) > $signed(cmp_y);
   assign take_a = (p_ff < ca_ff) && ((q_ff >= cb_ff) || cmp_lt);

   // Output space needed by the selected record
   assign fit_sum = (LENW+1)'(merged_count_ff) + (LENW+1)'(2)
                  + (has_a_ff ? (LENW+1)'(ca_ff) : '0)
                  + (has_b_ff ? (LENW+1)'(cb_ff) : '0);

   // Sequencer next state
   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      merged_count_in = merged_count_ff;
      error_in        = error_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      cmd_in          = cmd_ff;
      value_in        = value_ff;
      index_in        = index_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      ca_in           = ca_ff;
      cb_in           = cb_ff;
      p_in            = p_ff;
      q_in            = q_ff;
      need_in         = need_ff;
      ka_in           = ka_ff;
      kb_in           = kb_ff;
      word_in         = word_ff;
      code_in         = code_ff;
      has_a_in        = has_a_ff;
      has_b_in        = has_b_ff;
      src_b_in        = src_b_ff;
      rsp_data_in     = rsp_data_ff;
      fl_we           = 1'b0;
      fl_waddr        = AW'(first_count_ff);
      fl_wdata        = value_ff;
      fl_raddr        = AW'(a_ff);
      sl_we           = 1'b0;
      sl_waddr        = AW'(second_count_ff);
      sl_wdata        = value_ff;
      sl_raddr        = AW'(b_ff);
      ml_we           = 1'b0;
      ml_waddr        = IDXW'(merged_count_ff);
      ml_wdata        = ka_ff;
      ml_raddr        = index_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               value_in = req_tdata[W-1:0];
               index_in = req_tdata[W+IDXW-1:W];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            word_in  = '0;
            state_in = ST_RESP;
            case (cmd_ff)
               srlm_pkg::CMD_LOAD_FIRST: begin
                  if (first_count_ff < CNTW'(LIST_WORDS)) begin
                     fl_we          = 1'b1;
                     first_count_in = first_count_ff + 1'b1;
                  end else if (error_ff == srlm_pkg::STATUS_OK) begin
                     error_in = srlm_pkg::STATUS_RECORD_ERR;
                  end
               end
               srlm_pkg::CMD_LOAD_SECOND: begin
                  if (second_count_ff < CNTW'(LIST_WORDS)) begin
                     sl_we           = 1'b1;
                     second_count_in = second_count_ff + 1'b1;
                  end else if (error_ff == srlm_pkg::STATUS_OK) begin
                     error_in = srlm_pkg::STATUS_RECORD_ERR;
                  end
               end
               srlm_pkg::CMD_MERGE: begin
                  a_in            = '0;
                  b_in            = '0;
                  merged_count_in = '0;
                  code_in         = srlm_pkg::STATUS_OK;
                  state_in        = ST_A_CHK;
               end
               srlm_pkg::CMD_READ: begin
                  state_in = ST_READ_WAIT;
               end
               srlm_pkg::CMD_CLEAR: begin
                  first_count_in  = '0;
                  second_count_in = '0;
                  merged_count_in = '0;
                  error_in        = srlm_pkg::STATUS_OK;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_READ_WAIT: begin
            word_in  = (LENW'(index_ff) < merged_count_ff) ? ml_rdata : '0;
            state_in = ST_RESP;
         end

         // Find the next first-list record, skipping key -1
         ST_A_CHK: begin
            if (rec_at_end) begin
               has_a_in = 1'b0;
               state_in = ST_B_CHK;
            end else if (rec_short) begin
               code_in  = srlm_pkg::STATUS_RECORD_ERR;
               state_in = ST_FINISH;
            end else begin
               fl_raddr = AW'(a_ff + 1'b1);
               state_in = ST_A_CNT;
            end
         end

         ST_A_CNT: begin
            if (rec_cnt_bad) begin
               code_in  = srlm_pkg::STATUS_RECORD_ERR;
               state_in = ST_FINISH;
            end else begin
               ca_in    = CNTW'(rec_word);
               fl_raddr = AW'(a_ff);
               state_in = ST_A_KEY;
            end
         end

         ST_A_KEY: begin
            if (fl_rdata == {W{1'b1}}) begin
               a_in     = CNTW'(a_ff + ca_ff + 2'd2);
               state_in = ST_A_CHK;
            end else begin
               ka_in    = fl_rdata;
               has_a_in = 1'b1;
               state_in = ST_B_CHK;
            end
         end

         // Fetch the next second-list record
         ST_B_CHK: begin
            if (rec_at_end) begin
               has_b_in = 1'b0;
               state_in = ST_SEL;
            end else if (rec_short) begin
               code_in  = srlm_pkg::STATUS_RECORD_ERR;
               state_in = ST_FINISH;
            end else begin
               sl_raddr = AW'(b_ff + 1'b1);
               state_in = ST_B_CNT;
            end
         end

         ST_B_CNT: begin
            if (rec_cnt_bad) begin
               code_in  = srlm_pkg::STATUS_RECORD_ERR;
               state_in = ST_FINISH;
            end else begin
               cb_in    = CNTW'(rec_word);
               sl_raddr = AW'(b_ff);
               state_in = ST_B_KEY;
            end
         end

         ST_B_KEY: begin
            kb_in    = sl_rdata;
            has_b_in = 1'b1;
            state_in = ST_SEL;
         end

         // Pick the lower key, or both when equal
         ST_SEL: begin
            if (!has_a_ff && !has_b_ff) begin
               state_in = ST_FINISH;
            end else begin
               if (has_a_ff && has_b_ff && cmp_lt) begin
                  has_b_in = 1'b0;
               end else if (has_a_ff && has_b_ff && cmp_gt) begin
                  has_a_in = 1'b0;
               end
               state_in = ST_FIT;
            end
         end

         // Stop when the record would not fit in the output store, else start the record
         ST_FIT: begin
            p_in = '0;
            q_in = '0;
            if (fit_sum > (LENW+1)'(MW)) begin
               code_in  = srlm_pkg::STATUS_OVERFLOW;
               state_in = ST_FINISH;
            end else if (has_a_ff && has_b_ff) begin
               ml_we           = 1'b1;
               ml_wdata        = ka_ff;
               merged_count_in = merged_count_ff + 1'b1;
               state_in        = ST_W_CNT;
            end else begin
               src_b_in = !has_a_ff;
               need_in  = CNTW'((has_a_ff ? ca_ff : cb_ff) + 2'd2);
               state_in = ST_CP_RD;
            end
         end

         ST_W_CNT: begin
            ml_we           = 1'b1;
            ml_wdata        = W'((CNTW+1)'(ca_ff) + (CNTW+1)'(cb_ff));
            merged_count_in = merged_count_ff + 1'b1;
            state_in        = ST_MEM_RD;
         end

         // Member merge: fetch one member of each record
         ST_MEM_RD: begin
            if ((p_ff == ca_ff) && (q_ff == cb_ff)) begin
               a_in     = CNTW'(a_ff + ca_ff + 2'd2);
               b_in     = CNTW'(b_ff + cb_ff + 2'd2);
               state_in = ST_A_CHK;
            end else begin
               fl_raddr = AW'(a_ff + p_ff + 2'd2);
               sl_raddr = AW'(b_ff + q_ff + 2'd2);
               state_in = ST_MEM_CMP;
            end
         end

         ST_MEM_CMP: begin
            ml_we           = 1'b1;
            merged_count_in = merged_count_ff + 1'b1;
            if (take_a) begin
               ml_wdata = fl_rdata;
               p_in     = p_ff + 1'b1;
            end else begin
               ml_wdata = sl_rdata;
               q_in     = q_ff + 1'b1;
            end
            state_in = ST_MEM_RD;
         end

         // Copy a record found in one list only
         ST_CP_RD: begin
            if (p_ff == need_ff) begin
               if (src_b_ff) begin
                  b_in = CNTW'(b_ff + need_ff);
               end else begin
                  a_in = CNTW'(a_ff + need_ff);
               end
               state_in = ST_A_CHK;
            end else begin
               fl_raddr = AW'(a_ff + p_ff);
               sl_raddr = AW'(b_ff + p_ff);
               state_in = ST_CP_WR;
            end
         end

         ST_CP_WR: begin
            ml_we           = 1'b1;
            ml_wdata        = src_b_ff ? sl_rdata : fl_rdata;
            merged_count_in = merged_count_ff + 1'b1;
            p_in            = p_ff + 1'b1;
            state_in        = ST_CP_RD;
         end

         // Latch a merge error unless one is already pending
         ST_FINISH: begin
            word_in = '0;
            if ((code_ff != srlm_pkg::STATUS_OK) && (error_ff == srlm_pkg::STATUS_OK)) begin
               error_in = code_ff;
            end
            state_in = ST_RESP;
         end

         // Hold the response until the output register is free
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_DW'({error_ff, merged_count_ff, word_ff});
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         merged_count_ff <= '0;
         error_ff        <= srlm_pkg::STATUS_OK;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         merged_count_ff <= merged_count_in;
         error_ff        <= error_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      index_ff    <= index_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      need_ff     <= need_in;
      ka_ff       <= ka_in;
      kb_ff       <= kb_in;
      word_ff     <= word_in;
      code_ff     <= code_in;
      has_a_ff    <= has_a_in;
      has_b_ff    <= has_b_in;
      src_b_ff    <= src_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status is sticky: only a clear request changes a nonzero status
   `ASSERT_NEXT(a_status_sticky, clock, reset, (error_ff != srlm_pkg::STATUS_OK) && !((state_ff == ST_EXEC) && (cmd_ff == srlm_pkg::CMD_CLEAR)), error_ff == $past(error_ff))

   // List fill counts and output length stay within their stores
   `ASSERT_IMPLIES(a_counts_bounded, clock, reset, 1'b1, (first_count_ff <= CNTW'(LIST_WORDS)) && (second_count_ff <= CNTW'(LIST_WORDS)) && (merged_count_ff <= LENW'(MW)))

   // Outside request decode the output grows by at most one word per cycle
   `ASSERT_NEXT(a_merge_one_word, clock, reset, state_ff != ST_EXEC, (merged_count_ff == $past(merged_count_ff)) || (merged_count_ff == $past(merged_count_ff) + 1'b1))

endmodule
